// File: design/sliu_pkg.sv
`default_nettype none
package sliu_pkg;

  // Phase and fractions are Q.24 fixed point.
  localparam int FRAC_BITS = 24;

  // Register and field widths.
  localparam int RATIO_W   = 27;
  localparam int INV_W     = 29;
  localparam int INV_LO_W  = 16;
  localparam int INV_HI_W  = INV_W - INV_LO_W;
  localparam int PHASE_W   = 27;
  localparam int SUM_W     = FRAC_BITS + 4;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = INV_W;

  localparam logic [RATIO_W-1:0] RATIO_RESET   = RATIO_W'(15414067);
  localparam logic [INV_W-1:0]   INVERSE_RESET = INV_W'(18262980);

  // Defaults for the top-level parameters.
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int MAX_FRAMES_DEF      = 4;
  localparam int QUEUE_DEPTH_DEF     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_RATIO    = 1'b0,
    CFG_INVERSE_RATIO = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

// File: design/stereo_linear_interp_upsampler_top.sv
`default_nettype none
// Stereo linear-interpolation upsampler. Each accepted input beat adds rate_ratio
// (Q3.24) to a phase and causes as many output frames as the phase's whole part,
// at most MAX_FRAMES per input; each frame is interpolated between the previous
// and the current sample at fraction 1 - phase * inverse_ratio, clamped to 0..1,
// and the last frame of a run carries out_last_of_run. The front end takes one
// input beat per cycle while the queue has room; the back end's sequencer fetches
// each queue entry and then steps each frame through partial products, reciprocal
// sum, difference multiply and rounding, and holds in the rounding step while the
// output register is still full. An input that causes no frames is not queued.
// A finished frame waits in the output register while the next one is
// computed. Write configuration only while the block is idle.
module stereo_linear_interp_upsampler_top
  import sliu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_left,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_right,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [OUT_W-1:0]            out_frame_left,
  output logic signed [OUT_W-1:0]            out_frame_right,
  output logic                               out_last_of_run,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int ENTRY_W = 4 * SAMPLE_BITS + PHASE_W + CNT_W;

  logic [RATIO_W-1:0] rate_ratio_r;
  logic [INV_W-1:0]   inverse_ratio_r;
  logic               q_push, q_push_ready, q_valid, q_pop;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  logic [OUT_W-1:0]   frame_l, frame_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_ratio_r    <= RATIO_RESET;
      inverse_ratio_r <= INVERSE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RATE_RATIO:    rate_ratio_r    <= cfg_data[RATIO_W-1:0];
        CFG_INVERSE_RATIO: inverse_ratio_r <= cfg_data[INV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sliu_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_FRAMES  (MAX_FRAMES),
    .CNT_W       (CNT_W),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .rate_ratio      (rate_ratio_r),
    .q_push          (q_push),
    .q_ready         (q_push_ready),
    .q_data          (q_wdata)
  );

  sliu_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_data  (q_wdata),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_rdata)
  );

  sliu_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_FRAMES  (MAX_FRAMES),
    .CNT_W       (CNT_W),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_data          (q_rdata),
    .inverse_ratio   (inverse_ratio_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_left  (frame_l),
    .out_frame_right (frame_r),
    .out_last_of_run (out_last_of_run)
  );

  assign out_frame_left  = frame_l;
  assign out_frame_right = frame_r;

endmodule
`default_nettype wire

// File: design/sliu_front.sv
`default_nettype none
module sliu_front
  import sliu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int CNT_W       = $clog2(MAX_FRAMES + 1),
  parameter int ENTRY_W     = 4 * SAMPLE_BITS + PHASE_W + CNT_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_left,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_right,
  input  wire logic [RATIO_W-1:0]            rate_ratio,
  output logic                               q_push,
  input  wire logic                          q_ready,
  output logic [ENTRY_W-1:0]                 q_data
);

  logic signed [SAMPLE_BITS-1:0] prev_left_r, prev_right_r;
  logic [FRAC_BITS-1:0]          acc_r;
  logic [SUM_W-1:0]              phase;
  logic [SUM_W-FRAC_BITS-1:0]    whole;
  logic [CNT_W-1:0]              n_frames;
  logic                          accept;

  assign phase = SUM_W'(acc_r) + SUM_W'(rate_ratio);
  assign whole = phase[SUM_W-1:FRAC_BITS];

  // Frames this input causes: the whole part of the phase, capped.
  always_comb begin
    if (32'(whole) > 32'(MAX_FRAMES)) begin
      n_frames = CNT_W'(MAX_FRAMES);
    end else begin
      n_frames = CNT_W'(whole);
    end
  end

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (n_frames != '0);
  assign q_data   = {prev_left_r, prev_right_r, in_sample_left, in_sample_right,
                     phase[PHASE_W-1:0], n_frames};

  // Whether or not the run was capped, only the fraction of the phase survives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r  <= '0;
      prev_right_r <= '0;
      acc_r        <= '0;
    end else if (accept) begin
      prev_left_r  <= in_sample_left;
      prev_right_r <= in_sample_right;
      acc_r        <= phase[FRAC_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// File: design/sliu_fifo.sv
`default_nettype none
module sliu_fifo
  import sliu_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF  // power of two, at least 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != (AW + 1)'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (AW + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/sliu_back.sv
`default_nettype none
module sliu_back
  import sliu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int CNT_W       = $clog2(MAX_FRAMES + 1),
  parameter int ENTRY_W     = 4 * SAMPLE_BITS + PHASE_W + CNT_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire logic [ENTRY_W-1:0] q_data,
  input  wire logic [INV_W-1:0]   inverse_ratio,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [OUT_W-1:0]        out_frame_left,
  output logic [OUT_W-1:0]        out_frame_right,
  output logic                    out_last_of_run
);

  localparam int SB     = SAMPLE_BITS;
  localparam int PLO_W  = PHASE_W + INV_LO_W;
  localparam int PHI_W  = PHASE_W + INV_HI_W;
  localparam int PROD_W = PHASE_W + INV_W;
  localparam int FR_W   = FRAC_BITS + 1;
  localparam int MIX_W  = SB + FR_W + 2;
  localparam int EXT_W  = SB + OUT_W;
  localparam logic [PHASE_W-1:0] ONE_PH  = PHASE_W'(1) << FRAC_BITS;
  localparam logic [FR_W-1:0]    ONE_FR  = FR_W'(1) << FRAC_BITS;
  localparam logic [MIX_W-1:0]   HALF_MX = MIX_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_FRAC,
    S_MIX,
    S_FIN
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [PHASE_W-1:0]      ph_r;
  logic signed [SB-1:0]    prev_l_r, prev_r_r, cur_l_r, cur_r_r;
  logic [PLO_W-1:0]        plo_r;
  logic [PHI_W-1:0]        phi_r;
  logic [FR_W-1:0]         frac_r;
  logic signed [MIX_W-1:0] mix_l_r, mix_r_r;
  logic                    out_valid_r, out_last_r;
  logic [OUT_W-1:0]        out_left_r, out_right_r;

  logic [PROD_W-1:0]       prod_sum;
  logic [FR_W-1:0]         frac_nxt;
  logic signed [SB:0]      diff_l, diff_r;
  logic signed [MIX_W-1:0] fr_s, mix_l_nxt, mix_r_nxt;
  logic signed [MIX_W-1:0] step_l, step_r;
  logic signed [SB:0]      sum_l, sum_r;
  logic [EXT_W-1:0]        ext_l, ext_r;
  logic                    out_free;
  logic                    out_valid_nxt;

  // Queue entry layout: previous pair, current pair, phase, frame count.
  localparam int N_LO  = 0;
  localparam int PH_LO = CNT_W;
  localparam int CR_LO = PH_LO + PHASE_W;
  localparam int CL_LO = CR_LO + SB;
  localparam int PR_LO = CL_LO + SB;
  localparam int PL_LO = PR_LO + SB;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  // Reciprocal product from the two registered partial products.
  assign prod_sum = {phi_r, INV_LO_W'(0)} + PROD_W'(plo_r);
  always_comb begin
    if (|prod_sum[PROD_W-1:2*FRAC_BITS]) begin
      frac_nxt = '0;
    end else begin
      frac_nxt = ONE_FR - FR_W'(prod_sum[2*FRAC_BITS-1:FRAC_BITS]);
    end
  end

  assign diff_l    = (SB + 1)'(cur_l_r) - (SB + 1)'(prev_l_r);
  assign diff_r    = (SB + 1)'(cur_r_r) - (SB + 1)'(prev_r_r);
  assign fr_s      = MIX_W'(frac_r);
  assign mix_l_nxt = MIX_W'(diff_l) * fr_s;
  assign mix_r_nxt = MIX_W'(diff_r) * fr_s;

  // Rounded half up: arithmetic shift of the biased product floors it.
  assign step_l = (mix_l_r + HALF_MX) >>> FRAC_BITS;
  assign step_r = (mix_r_r + HALF_MX) >>> FRAC_BITS;
  assign sum_l  = (SB + 1)'(prev_l_r) + step_l[SB:0];
  assign sum_r  = (SB + 1)'(prev_r_r) + step_r[SB:0];
  assign ext_l  = {{OUT_W{sum_l[SB-1]}}, sum_l[SB-1:0]};
  assign ext_r  = {{OUT_W{sum_r[SB-1]}}, sum_r[SB-1:0]};

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if ((state_r == S_FIN) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            prev_l_r <= q_data[PL_LO +: SB];
            prev_r_r <= q_data[PR_LO +: SB];
            cur_l_r  <= q_data[CL_LO +: SB];
            cur_r_r  <= q_data[CR_LO +: SB];
            ph_r     <= q_data[PH_LO +: PHASE_W] - ONE_PH;
            cnt_r    <= q_data[N_LO +: CNT_W];
            state_r  <= S_PROD;
          end
        end
        S_PROD: begin
          plo_r   <= PLO_W'(ph_r) * PLO_W'(inverse_ratio[INV_LO_W-1:0]);
          phi_r   <= PHI_W'(ph_r) * PHI_W'(inverse_ratio[INV_W-1:INV_LO_W]);
          state_r <= S_FRAC;
        end
        S_FRAC: begin
          frac_r  <= frac_nxt;
          state_r <= S_MIX;
        end
        S_MIX: begin
          mix_l_r <= mix_l_nxt;
          mix_r_r <= mix_r_nxt;
          state_r <= S_FIN;
        end
        S_FIN: begin
          // Hold the finished frame here until the output register frees up.
          if (out_free) begin
            out_left_r  <= ext_l[OUT_W-1:0];
            out_right_r <= ext_r[OUT_W-1:0];
            out_last_r  <= cnt_r == CNT_W'(1);
            if (cnt_r == CNT_W'(1)) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r   <= cnt_r - CNT_W'(1);
              ph_r    <= ph_r - ONE_PH;
              state_r <= S_PROD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_left  = out_left_r;
  assign out_frame_right = out_right_r;
  assign out_last_of_run = out_last_r;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sliu_pkg::*;

  localparam int SMP_W         = SAMPLE_BITS_DEF;
  localparam int SETTLE_CYCLES = 80;
  localparam int LIMIT_CYCLES  = 400000;
  localparam longint unsigned ONE_Q       = 64'd1 << FRAC_BITS;
  localparam longint unsigned PHASE_MASK  = (64'd1 << PHASE_W) - 64'd1;
  localparam logic [INV_W-1:0] INVERSE_MAX = {INV_W{1'b1}};

  typedef struct packed {
    logic signed [OUT_W-1:0] frame_left;
    logic signed [OUT_W-1:0] frame_right;
    logic                    last_of_run;
  } frame_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SMP_W-1:0] in_sample_left = '0;
  logic signed [SMP_W-1:0] in_sample_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_frame_left;
  logic signed [OUT_W-1:0] out_frame_right;
  logic out_last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RATE_RATIO;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the block's registers and state.
  logic [RATIO_W-1:0] cur_ratio = RATIO_RESET;
  logic [INV_W-1:0] cur_inverse = INVERSE_RESET;
  logic signed [SMP_W-1:0] last_left = '0;
  logic signed [SMP_W-1:0] last_right = '0;
  logic [PHASE_W-1:0] cur_phase = '0;

  frame_t expected_frames[$];
  int mismatches = 0;
  int frames_checked = 0;
  int samples_sent = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  rx_mode_t rx_mode = RX_ALWAYS;
  int rx_hold = 0;

  stereo_linear_interp_upsampler_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_left  (out_frame_left),
    .out_frame_right (out_frame_right),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [OUT_W-1:0] lerp_sample(input logic signed [SMP_W-1:0] a,
                                                          input logic signed [SMP_W-1:0] b,
                                                          input longint unsigned frac);
    longint diff;
    longint prod;
    diff = longint'(b) - longint'(a);
    // Adding half an LSB and flooring gives round half toward plus infinity.
    prod = diff * longint'(frac) + (longint'(1) << (FRAC_BITS - 1));
    return OUT_W'(longint'(a) + (prod >>> FRAC_BITS));
  endfunction

  function automatic void predict_upsample(input logic signed [SMP_W-1:0] cur_left,
                                           input logic signed [SMP_W-1:0] cur_right);
    longint unsigned phase;
    longint unsigned prod;
    longint unsigned frac;
    frame_t run[MAX_FRAMES_DEF];
    int n;
    phase = 64'(cur_phase) + 64'(cur_ratio);
    n = 0;
    while (phase >= ONE_Q && n < MAX_FRAMES_DEF) begin
      phase = phase - ONE_Q;
      prod = ((phase & PHASE_MASK) * 64'(cur_inverse)) >> FRAC_BITS;
      frac = (prod >= ONE_Q) ? 64'd0 : ONE_Q - prod;
      run[n].frame_left = lerp_sample(last_left, cur_left, frac);
      run[n].frame_right = lerp_sample(last_right, cur_right, frac);
      run[n].last_of_run = 1'b0;
      n++;
    end
    // Too many frames for one input: the whole part of the phase is dropped.
    if (phase >= ONE_Q) phase = phase & (ONE_Q - 64'd1);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) run[i].last_of_run = 1'b1;
      expected_frames.push_back(run[i]);
    end
    cur_phase = PHASE_W'(phase);
    last_left = cur_left;
    last_right = cur_right;
  endfunction

  function automatic logic [INV_W-1:0] reciprocal_of(input logic [RATIO_W-1:0] ratio);
    longint unsigned q;
    q = (64'd1 << (2 * FRAC_BITS)) / 64'(ratio);
    return (q > 64'(INVERSE_MAX)) ? INVERSE_MAX : INV_W'(q);
  endfunction

  function automatic logic signed [SMP_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(SMP_W-1){1'b0}}};
      1: return {1'b0, {(SMP_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Receiver ready pattern.
  always @(negedge clk) begin
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold <= rx_hold - 1;
        end else begin
          out_ready <= ~out_ready;
          rx_hold <= out_ready ? $urandom_range(0, 12) : $urandom_range(0, 6);
        end
      end
    endcase
  end

  // Compare each output beat with the oldest predicted frame.
  always @(posedge clk) begin
    frame_t exp_frame;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected frame: left %0d right %0d last %0b",
               out_frame_left, out_frame_right, out_last_of_run);
        mismatches++;
      end else begin
        exp_frame = expected_frames.pop_front();
        frames_checked++;
        if (out_frame_left !== exp_frame.frame_left) begin
          $error("frame_left: expected %0d, got %0d", exp_frame.frame_left, out_frame_left);
          mismatches++;
        end
        if (out_frame_right !== exp_frame.frame_right) begin
          $error("frame_right: expected %0d, got %0d", exp_frame.frame_right, out_frame_right);
          mismatches++;
        end
        if (out_last_of_run !== exp_frame.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", exp_frame.last_of_run, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out with %0d frames outstanding", expected_frames.size());
    $display("Mismatches found");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_sample(input logic signed [SMP_W-1:0] left,
                             input logic signed [SMP_W-1:0] right);
    in_valid = 1'b1;
    in_sample_left = left;
    in_sample_right = right;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_upsample(left, right);
    samples_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait until the block has emptied out.
  task automatic drain_frames();
    in_valid = 1'b0;
    @(negedge clk);
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == CFG_RATE_RATIO) cur_ratio = data[RATIO_W-1:0];
    else cur_inverse = data[INV_W-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  task automatic set_rates(input logic [CFG_DATA_W-1:0] ratio_word,
                           input logic [INV_W-1:0] inverse);
    write_register(CFG_RATE_RATIO, ratio_word);
    write_register(CFG_INVERSE_RATIO, inverse);
  endtask

  task automatic send_stream(input int count, input int gap_max);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      send_sample(random_sample(), random_sample());
      burst--;
      if (i == count / 2 || $urandom_range(0, 49) == 0) drain_frames();
    end
    in_valid = 1'b0;
  endtask

  task automatic test_reset_defaults();
    rx_mode = RX_ALWAYS;
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh5555, 16'shaaaa);
    send_sample(16'shaaaa, 16'sh5555);
    drain_frames();
  endtask

  task automatic test_zero_ratio();
    // With no phase advance the block must stay silent.
    set_rates('0, INVERSE_RESET);
    repeat (3) send_sample(random_sample(), random_sample());
    drain_frames();
  endtask

  task automatic test_frame_limit();
    rx_mode = RX_RANDOM;
    set_rates(CFG_DATA_W'(64'd1 << 26), INV_W'(64'd1 << 22));
    repeat (3) send_sample(random_sample(), random_sample());
    drain_frames();
    set_rates(CFG_DATA_W'((64'd1 << RATIO_W) - 64'd1), INV_W'(64'd1 << 22));
    repeat (3) send_sample(random_sample(), random_sample());
    drain_frames();
  endtask

  task automatic test_inconsistent_rates();
    rx_mode = RX_BURSTY;
    // A huge reciprocal clamps the fraction to zero.
    set_rates(CFG_DATA_W'(ONE_Q), INVERSE_MAX);
    repeat (2) send_sample(random_sample(), random_sample());
    drain_frames();
    set_rates(CFG_DATA_W'(3 * (ONE_Q >> 1)), INV_W'(64'd1 << 22));
    repeat (2) send_sample(random_sample(), random_sample());
    drain_frames();
    set_rates(CFG_DATA_W'(1), INVERSE_RESET);
    repeat (2) send_sample(random_sample(), random_sample());
    drain_frames();
  endtask

  task automatic test_random_streams();
    logic [RATIO_W-1:0] ratio;
    logic [INV_W-1:0] inverse;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: ratio = RATIO_W'($urandom_range(1 << 23, 1 << 24));
        1: ratio = RATIO_W'($urandom_range(1 << 24, 1 << 26));
        2: ratio = RATIO_W'($urandom_range(1 << 21, 1 << 23));
        3: ratio = RATIO_W'(64'd1 << 26);
        default: ratio = RATIO_W'($urandom);
      endcase
      if (ratio == '0) ratio = RATIO_W'(1);
      inverse = (p >= 4) ? INV_W'($urandom) : reciprocal_of(ratio);
      // The two spare data bits of a ratio write are random; they must be dropped.
      write_register(CFG_RATE_RATIO, {2'($urandom), ratio});
      write_register(CFG_INVERSE_RATIO, inverse);
      rx_mode = rx_mode_t'(p % 3);
      send_stream(65, (p % 2 == 0) ? 10 : 0);
      drain_frames();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_zero_ratio();
    test_frame_limit();
    test_inconsistent_rates();
    test_random_streams();
    $display("Sent %0d samples, checked %0d frames, made %0d register writes.",
             samples_sent, frames_checked, reg_writes);
    $display("Ratios covered zero, one LSB, 4.0 and full width, with saturated and mismatched reciprocals.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: stereo_linear_interp_upsampler_top.f
design/sliu_pkg.sv
design/sliu_front.sv
design/sliu_fifo.sv
design/sliu_back.sv
design/stereo_linear_interp_upsampler_top.sv
tb/tb_top.sv
